/* hw/rtl/assert_macros.svh */
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define UPS_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define UPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define UPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UPS_ASSERT(label, clk, rst, expr)
`define UPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/ups_pkg.sv */
// types and constants of the update packet sequencer
package ups_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 64;
  localparam int unsigned PAGE_PACKETS_DEF = 8;

  localparam logic [15:0] FINAL_NUM = 16'hFFFF;
  localparam logic [15:0] FIRST_NUM = 16'h0001;

  localparam logic [15:0] REGION_BASE_RST = 16'h7000;
  localparam logic [15:0] FLASH_LIMIT_RST = 16'hFBFF;
  localparam logic [7:0]  TIMEOUT_RST     = 8'd10;
  localparam logic [7:0]  LAUNCH_RST      = 8'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_BASE   = 2'd0,
    REG_FLASH_LIMIT   = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2,
    REG_LAUNCH_TICKS  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] region_base;
    logic [15:0] flash_limit;
    logic [7:0]  timeout_ticks;
    logic [7:0]  launch_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] expected_num;
    logic        timer_on;
    logic [7:0]  tick_count;
    logic        launch_pending;
  } seq_state_t;

  typedef struct packed {
    logic        ack_valid;
    logic [15:0] ack_seq;
    logic        erase_req;
    logic [15:0] erase_addr;
    logic        write_req;
    logic [15:0] write_addr;
    logic        launch_update;
  } result_t;

endpackage

/* hw/rtl/ups_if.sv */
// handshake channels of the update packet sequencer
interface ups_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] packet_num;

  modport source (output valid, cmd, packet_num, input ready);
  modport sink (input valid, cmd, packet_num, output ready);
endinterface

interface ups_result_if;
  logic        valid;
  logic        ready;
  logic        ack_valid;
  logic [15:0] ack_seq;
  logic        erase_req;
  logic [15:0] erase_addr;
  logic        write_req;
  logic [15:0] write_addr;
  logic        launch_update;

  modport source (output valid, ack_valid, ack_seq, erase_req, erase_addr, write_req,
                  write_addr, launch_update, input ready);
  modport sink (input valid, ack_valid, ack_seq, erase_req, erase_addr, write_req,
                write_addr, launch_update, output ready);
endinterface

interface ups_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ups_step.sv */
// next state and result for one packet or tick
module ups_step #(
  parameter int unsigned PACKET_BYTES = 64,
  parameter int unsigned PAGE_PACKETS = 8,
  localparam int unsigned PW = (PAGE_PACKETS > 1) ? $clog2(PAGE_PACKETS) : 1
) (
  input  ups_pkg::cfg_t       cfg,
  input  ups_pkg::seq_state_t cur,
  input  logic [PW-1:0]       page_pos,
  input  logic                cmd,
  input  logic [15:0]         packet_num,
  output ups_pkg::seq_state_t nxt,
  output logic [PW-1:0]       page_pos_next,
  output ups_pkg::result_t    res
);
  import ups_pkg::*;

  localparam int unsigned PB_W = $clog2(PACKET_BYTES + 1);
  localparam int unsigned PROD_W = PB_W + 16;
  localparam logic [PW-1:0] POS_LAST = PW'(PAGE_PACKETS - 1);

  logic [15:0]       idx;
  logic [PROD_W-1:0] prod;
  logic [15:0]       slot_addr;
  logic              in_range;
  logic              normal;
  logic              final_pkt;
  logic [PW-1:0]     pos_inc;
  logic [7:0]        tick_inc;

  assign idx       = cur.expected_num - 16'd1;
  assign prod      = PROD_W'(idx) * PROD_W'(PACKET_BYTES);
  assign slot_addr = prod[15:0] + cfg.region_base;
  assign in_range  = slot_addr <= cfg.flash_limit;
  assign normal    = (packet_num == cur.expected_num) && (packet_num != FINAL_NUM);
  assign final_pkt = (packet_num == FINAL_NUM) && (cur.expected_num != FIRST_NUM);
  assign pos_inc   = (page_pos == POS_LAST) ? '0 : page_pos + PW'(1);
  assign tick_inc  = cur.tick_count + 8'd1;

  always_comb begin
    nxt           = cur;
    page_pos_next = page_pos;
    res           = '0;
    unique case (cmd_t'(cmd))
      CMD_PACKET: begin
        res.ack_valid  = 1'b1;
        nxt.tick_count = '0;
        if (normal || final_pkt) begin
          if (in_range) begin
            res.write_req  = 1'b1;
            res.write_addr = slot_addr;
            if (page_pos == '0) begin
              res.erase_req  = 1'b1;
              res.erase_addr = slot_addr;
            end
          end
          nxt.timer_on = 1'b1;
          if (normal) begin
            nxt.expected_num = cur.expected_num + 16'd1;
            page_pos_next    = pos_inc;
            res.ack_seq      = cur.expected_num + 16'd1;
          end else begin
            nxt.expected_num   = FIRST_NUM;
            page_pos_next      = '0;
            nxt.launch_pending = 1'b1;
            res.ack_seq        = FINAL_NUM;
          end
        end else begin
          nxt.timer_on = 1'b0;
          res.ack_seq  = cur.expected_num;
        end
      end
      CMD_TICK: begin
        if (cur.timer_on) begin
          nxt.tick_count = tick_inc;
          if (cur.tick_count > cfg.timeout_ticks) begin
            nxt.expected_num = FIRST_NUM;
            page_pos_next    = '0;
            nxt.timer_on     = 1'b0;
          end
          if (cur.launch_pending && (tick_inc > cfg.launch_ticks)) begin
            res.launch_update  = 1'b1;
            nxt.launch_pending = 1'b0;
            nxt.timer_on       = 1'b0;
          end
        end else begin
          nxt.tick_count = '0;
        end
      end
    endcase
  end

endmodule

/* hw/rtl/update_packet_sequencer.sv */
// top level of the update packet sequencer
// a result is valid in the cycle after its item transaction
// throughput: one item per cycle, stalled while a held result is not taken; the
// result register frees as its transaction completes; the state update and result
// come from a single step of logic between the state registers and the result register
// reset (synchronous): registers to defaults, expected number 1, result register empty
`include "assert_macros.svh"

module update_packet_sequencer #(
  parameter int unsigned PACKET_BYTES = ups_pkg::PACKET_BYTES_DEF,
  parameter int unsigned PAGE_PACKETS = ups_pkg::PAGE_PACKETS_DEF
) (
  input logic           clk,
  input logic           rst,
  ups_cfg_if.sink       cfg,
  ups_item_if.sink      item,
  ups_result_if.source  result
);
  import ups_pkg::*;

  localparam int unsigned PW = (PAGE_PACKETS > 1) ? $clog2(PAGE_PACKETS) : 1;

  cfg_t          regs;
  seq_state_t    state;
  seq_state_t    state_next;
  logic [PW-1:0] page_pos;
  logic [PW-1:0] page_pos_next;
  result_t       res_next;
  result_t       res;
  logic          res_valid;
  logic          item_fire;

  assign cfg.ready  = 1'b1;
  assign item.ready = !res_valid || result.ready;
  assign item_fire  = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.region_base   <= REGION_BASE_RST;
      regs.flash_limit   <= FLASH_LIMIT_RST;
      regs.timeout_ticks <= TIMEOUT_RST;
      regs.launch_ticks  <= LAUNCH_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_REGION_BASE:   regs.region_base   <= cfg.data;
        REG_FLASH_LIMIT:   regs.flash_limit   <= cfg.data;
        REG_TIMEOUT_TICKS: regs.timeout_ticks <= cfg.data[7:0];
        REG_LAUNCH_TICKS:  regs.launch_ticks  <= cfg.data[7:0];
      endcase
    end
  end

  ups_step #(
    .PACKET_BYTES (PACKET_BYTES),
    .PAGE_PACKETS (PAGE_PACKETS)
  ) u_step (
    .cfg           (regs),
    .cur           (state),
    .page_pos      (page_pos),
    .cmd           (item.cmd),
    .packet_num    (item.packet_num),
    .nxt           (state_next),
    .page_pos_next (page_pos_next),
    .res           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.expected_num   <= FIRST_NUM;
      state.timer_on       <= 1'b0;
      state.tick_count     <= '0;
      state.launch_pending <= 1'b0;
      page_pos             <= '0;
      res_valid            <= 1'b0;
    end else begin
      if (item_fire) begin
        state    <= state_next;
        page_pos <= page_pos_next;
      end
      if (item_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.ack_valid     = res.ack_valid;
  assign result.ack_seq       = res.ack_seq;
  assign result.erase_req     = res.erase_req;
  assign result.erase_addr    = res.erase_addr;
  assign result.write_req     = res.write_req;
  assign result.write_addr    = res.write_addr;
  assign result.launch_update = res.launch_update;

  `UPS_ASSERT(a_expected_nonzero, clk, rst, state.expected_num != 16'd0)
  `UPS_ASSERT(a_page_pos_range, clk, rst, 32'(page_pos) < PAGE_PACKETS)
  `UPS_ASSERT_NEXT(a_item_gives_result, clk, rst, item_fire, res_valid)
  `UPS_ASSERT_IMPL(a_erase_with_write, clk, rst, res_valid && res.erase_req, res.write_req && (res.erase_addr == res.write_addr))
  `UPS_ASSERT_IMPL(a_launch_on_tick, clk, rst, res_valid && res.launch_update, !res.ack_valid && !res.write_req)

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench of the update packet sequencer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ups_pkg::*;

  localparam int unsigned SLOT_BYTES  = PACKET_BYTES_DEF;
  localparam int unsigned PAGE_SLOTS  = PAGE_PACKETS_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_SLACK = 4;
  localparam int unsigned PHASE_ITEMS = 200;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HOLD
  } stall_style_t;

  logic clk = 1'b0;
  logic rst;

  ups_cfg_if    cfg_bus ();
  ups_item_if   item_bus ();
  ups_result_if result_bus ();

  update_packet_sequencer DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  cfg_t         flash_cfg;
  seq_state_t   seq;
  result_t      responses_due[$];
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  quiet_cycles = 0;
  logic         sender_gaps = 1'b1;
  stall_style_t stall_style = STALL_RANDOM;

  always #5 clk = ~clk;

  function automatic result_t advance_sequencer(input cmd_t op, input logic [15:0] num);
    result_t     r;
    logic        in_order;
    logic        last_pkt;
    logic [15:0] idx;
    logic [15:0] slot;
    logic [31:0] wide;
    logic [7:0]  old_ticks;
    r = '0;
    if (op == CMD_PACKET) begin
      in_order = (num == seq.expected_num) && (num != FINAL_NUM);
      last_pkt = (num == FINAL_NUM) && (seq.expected_num != FIRST_NUM);
      r.ack_valid = 1'b1;
      if (in_order || last_pkt) begin
        idx  = seq.expected_num - FIRST_NUM;
        wide = 32'(idx) * SLOT_BYTES + 32'(flash_cfg.region_base);
        slot = wide[15:0];
        if (slot <= flash_cfg.flash_limit) begin
          r.write_req  = 1'b1;
          r.write_addr = slot;
          if (idx % PAGE_SLOTS == 0) begin
            r.erase_req  = 1'b1;
            r.erase_addr = slot;
          end
        end
        seq.timer_on = 1'b1;
        if (in_order) begin
          seq.expected_num = seq.expected_num + 16'd1;
          r.ack_seq = seq.expected_num;
        end else begin
          r.ack_seq = FINAL_NUM;
          seq.launch_pending = 1'b1;
          seq.expected_num = FIRST_NUM;
        end
      end else begin
        seq.timer_on = 1'b0;
        r.ack_seq = seq.expected_num;
      end
      seq.tick_count = '0;
    end else if (seq.timer_on) begin
      old_ticks = seq.tick_count;
      seq.tick_count = seq.tick_count + 8'd1;
      if (old_ticks > flash_cfg.timeout_ticks) begin
        seq.expected_num = FIRST_NUM;
        seq.timer_on = 1'b0;
      end
      if (seq.launch_pending && seq.tick_count > flash_cfg.launch_ticks) begin
        r.launch_update = 1'b1;
        seq.launch_pending = 1'b0;
        seq.timer_on = 1'b0;
      end
    end else begin
      seq.tick_count = '0;
    end
    return r;
  endfunction

  task automatic send_item(input cmd_t op, input logic [15:0] num);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    item_bus.valid      <= 1'b1;
    item_bus.cmd        <= op;
    item_bus.packet_num <= num;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    responses_due.push_back(advance_sequencer(op, num));
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(CMD_TICK, 16'($urandom));
  endtask

  task automatic wait_for_responses();
    item_bus.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_REGION_BASE:   flash_cfg.region_base   = value;
      REG_FLASH_LIMIT:   flash_cfg.flash_limit   = value;
      REG_TIMEOUT_TICKS: flash_cfg.timeout_ticks = value[7:0];
      REG_LAUNCH_TICKS:  flash_cfg.launch_ticks  = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] base, input logic [15:0] limit,
                            input logic [15:0] timeout, input logic [15:0] launch);
    wait_for_responses();
    write_register(REG_REGION_BASE, base);
    write_register(REG_FLASH_LIMIT, limit);
    write_register(REG_TIMEOUT_TICKS, timeout);
    write_register(REG_LAUNCH_TICKS, launch);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic note_failure(input string what, input result_t want, input result_t got);
    if (error_count < 10) begin
      $display("%s: expected ack %0b/%h erase %0b/%h write %0b/%h launch %0b",
               what, want.ack_valid, want.ack_seq, want.erase_req, want.erase_addr,
               want.write_req, want.write_addr, want.launch_update);
      $display("  got ack %0b/%h erase %0b/%h write %0b/%h launch %0b",
               got.ack_valid, got.ack_seq, got.erase_req, got.erase_addr,
               got.write_req, got.write_addr, got.launch_update);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      seen.ack_valid     = result_bus.ack_valid;
      seen.ack_seq       = result_bus.ack_seq;
      seen.erase_req     = result_bus.erase_req;
      seen.erase_addr    = result_bus.erase_addr;
      seen.write_req     = result_bus.write_req;
      seen.write_addr    = result_bus.write_addr;
      seen.launch_update = result_bus.launch_update;
      if (responses_due.size() == 0) begin
        note_failure("unexpected transaction", '0, seen);
      end else begin
        want = responses_due.pop_front();
        if (seen.ack_valid !== want.ack_valid || seen.ack_seq !== want.ack_seq ||
            seen.erase_req !== want.erase_req || seen.erase_addr !== want.erase_addr ||
            seen.write_req !== want.write_req || seen.write_addr !== want.write_addr ||
            seen.launch_update !== want.launch_update)
          note_failure("mismatch", want, seen);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    int unsigned hold_left;
    cycle_count = 0;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_count++;
      case (stall_style)
        STALL_NONE:     result_bus.ready <= 1'b1;
        STALL_RANDOM:   result_bus.ready <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: result_bus.ready <= ((cycle_count % 7) < 4);
        default: begin
          if (hold_left != 0) begin
            result_bus.ready <= 1'b0;
            hold_left--;
          end else begin
            result_bus.ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("update_packet_sequencer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_page_sequence();
    for (int n = 1; n <= 9; n++) send_item(CMD_PACKET, 16'(n));
  endtask

  task automatic test_stray_packets();
    send_item(CMD_PACKET, 16'd3);
    send_item(CMD_PACKET, 16'hFFFE);
    send_item(CMD_PACKET, 16'h0000);
  endtask

  task automatic test_final_launch();
    send_item(CMD_PACKET, seq.expected_num);
    send_item(CMD_PACKET, FINAL_NUM);
    send_ticks(5);
    send_item(CMD_PACKET, FINAL_NUM);
  endtask

  task automatic test_timeout_restart();
    set_config(REGION_BASE_RST, FLASH_LIMIT_RST, 16'd0, LAUNCH_RST);
    send_item(CMD_PACKET, FIRST_NUM);
    send_ticks(2);
    send_item(CMD_PACKET, 16'd2);
    send_item(CMD_PACKET, FIRST_NUM);
  endtask

  task automatic test_flash_limit();
    set_config(16'hFFC0, 16'hFFFF, TIMEOUT_RST, LAUNCH_RST);
    send_item(CMD_PACKET, FINAL_NUM);
    send_item(CMD_PACKET, FIRST_NUM);
    set_config(16'hFFC0, 16'h0000, TIMEOUT_RST, LAUNCH_RST);
    send_item(CMD_PACKET, 16'd2);
    send_item(CMD_PACKET, 16'd3);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned run_len;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(REGION_BASE_RST, FLASH_LIMIT_RST, TIMEOUT_RST, LAUNCH_RST);
        1: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: set_config(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h00FF);
        default: set_config(16'($urandom), 16'($urandom),
                            {8'($urandom), 8'($urandom_range(0, 20))},
                            {8'($urandom), 8'($urandom_range(0, 8))});
      endcase
      sender_gaps = (p != 0);
      stall_style = stall_style_t'(p % 4);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
              send_item(CMD_PACKET, seq.expected_num);
              if ($urandom_range(0, 7) == 0) send_ticks($urandom_range(1, 2));
            end
            if ($urandom_range(0, 1) == 0) begin
              send_item(CMD_PACKET, FINAL_NUM);
              if ($urandom_range(0, 3) == 0) send_ticks(flash_cfg.launch_ticks + 2);
              else send_ticks($urandom_range(0, 6));
            end
          end
          6: begin
            if ($urandom_range(0, 3) == 0) send_ticks(flash_cfg.timeout_ticks + 2);
            else send_ticks($urandom_range(1, 16));
          end
          7: begin
            case ($urandom_range(0, 2))
              0: send_item(CMD_PACKET, 16'($urandom));
              1: send_item(CMD_PACKET, seq.expected_num - 16'd1);
              default: send_item(CMD_PACKET, seq.expected_num + 16'd1);
            endcase
          end
          8: send_item(CMD_PACKET, FINAL_NUM);
          default: send_ticks(1);
        endcase
        if ($urandom_range(0, 60) == 0) wait_for_responses();
      end
    end
  endtask

  initial begin
    flash_cfg.region_base   = REGION_BASE_RST;
    flash_cfg.flash_limit   = FLASH_LIMIT_RST;
    flash_cfg.timeout_ticks = TIMEOUT_RST;
    flash_cfg.launch_ticks  = LAUNCH_RST;
    seq.expected_num   = FIRST_NUM;
    seq.timer_on       = 1'b0;
    seq.tick_count     = '0;
    seq.launch_pending = 1'b0;
    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.cmd        <= CMD_PACKET;
    item_bus.packet_num <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_REGION_BASE;
    cfg_bus.data        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_page_sequence();
    test_stray_packets();
    test_final_launch();
    test_timeout_restart();
    test_flash_limit();
    test_random_traffic();

    wait_for_responses();
    error_count += responses_due.size();
    if (error_count == 0)
      $display("update_packet_sequencer regression: pass");
    else
      $display("update_packet_sequencer regression: fail");
    $finish;
  end

endmodule
